// ===== rtl/core/sorted_priority_list_top_macros.svh =====
// Assertion macros for the sorted priority list checker.
// Used by spl_checker.sv; expects clk and arst_n in the including scope.
`ifndef SORTED_PRIORITY_LIST_TOP_MACROS_SVH
`define SORTED_PRIORITY_LIST_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is held
`define SPL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well
`define SPL_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/spl_pkg.sv =====
// Package for the sorted priority list: field widths, command and status
// codes, and the control/status structs between controller and datapath.
package spl_pkg;

	localparam int CMD_W     = 3;
	localparam int ID_W      = 16;
	localparam int PRIO_W    = 8;
	localparam int ST_W      = 2;
	localparam int POS_W     = 5;
	localparam int DEPTH_DEF = 16;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REPRIO  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FIND    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LIST    = 3'd4;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

	// commands from controller to datapath
	typedef struct packed {
		logic            capture;    // latch the incoming request
		logic            idx_clr;    // scan index back to zero
		logic            idx_inc;    // advance scan index
		logic            do_insert;  // insert request at scan index
		logic            do_delete;  // delete entry at scan index
		logic            save_match; // keep matched entry as result
		logic            load_out;   // load the output register
		logic            out_list;   // output comes from the slot at scan index
		logic [ST_W-1:0] out_status; // status for a single result
	} spl_ctrl_t;

	// status from datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;       // captured command
		logic             empty;
		logic             full;
		logic             scan_end;  // index reached fill count
		logic             id_match;  // slot id equals requested id
		logic             prio_le;   // slot priority <= requested priority
		logic             list_last; // index is the final occupied slot
		logic             out_free;  // output register can take a result
	} spl_stat_t;

endpackage

// ===== rtl/core/spl_cmd_if.sv =====
// Request channel of the sorted priority list: valid/ready plus command fields.
// Depends on spl_pkg for field widths.
interface spl_cmd_if;
	import spl_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [ID_W-1:0]   patient_id;
	logic [PRIO_W-1:0] priority_req;

	modport source (output valid, command, patient_id, priority_req, input ready);
	modport sink (input valid, command, patient_id, priority_req, output ready);

endinterface

// ===== rtl/core/spl_res_if.sv =====
// Result channel of the sorted priority list: valid/ready plus result fields.
// Depends on spl_pkg for field widths.
interface spl_res_if;
	import spl_pkg::*;

	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [ID_W-1:0]   entry_id;
	logic [PRIO_W-1:0] entry_priority;
	logic [POS_W-1:0]  position;
	logic [POS_W-1:0]  occupancy;
	logic              last;

	modport source (output valid, status, entry_id, entry_priority, position,
		occupancy, last, input ready);
	modport sink (input valid, status, entry_id, entry_priority, position,
		occupancy, last, output ready);

endinterface

// ===== rtl/core/spl_ctrl.sv =====
// Controller state machine of the sorted priority list.
// Depends on spl_pkg; drives spl_datapath through spl_ctrl_t.
module spl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  spl_pkg::spl_stat_t stat,
	output spl_pkg::spl_ctrl_t ctrl
);
	import spl_pkg::*;

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_DECODE    = 3'd1;
	localparam logic [2:0] S_SCAN_ID   = 3'd2;
	localparam logic [2:0] S_SCAN_PRIO = 3'd3;
	localparam logic [2:0] S_LIST      = 3'd4;
	localparam logic [2:0] S_EMIT      = 3'd5;

	logic [2:0]      state_q, state_d;
	logic [ST_W-1:0] res_status_q, res_status_d;

	// state and pending status registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			res_status_q <= ST_OK;
		end else begin
			state_q      <= state_d;
			res_status_q <= res_status_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d         = state_q;
		res_status_d    = res_status_q;
		in_ready        = 1'b0;
		ctrl            = '0;
		ctrl.out_status = res_status_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.capture = 1'b1;
					ctrl.idx_clr = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.cmd)
					CMD_ADD: begin
						if (stat.full) begin
							res_status_d = ST_FULL;
							state_d      = S_EMIT;
						end else begin
							state_d = S_SCAN_PRIO;
						end
					end
					CMD_REMOVE, CMD_REPRIO, CMD_FIND: begin
						if (stat.empty) begin
							res_status_d = ST_EMPTY;
							state_d      = S_EMIT;
						end else begin
							state_d = S_SCAN_ID;
						end
					end
					CMD_LIST: begin
						if (stat.empty) begin
							res_status_d = ST_EMPTY;
							state_d      = S_EMIT;
						end else begin
							state_d = S_LIST;
						end
					end
					default: state_d = S_IDLE; // unused codes give no result
				endcase
			end
			// walk past entries of lower or equal priority, then insert
			S_SCAN_PRIO: begin
				if (!stat.scan_end && stat.prio_le) begin
					ctrl.idx_inc = 1'b1;
				end else begin
					ctrl.do_insert = 1'b1;
					res_status_d   = ST_OK;
					state_d        = S_EMIT;
				end
			end
			// first entry with the requested id
			S_SCAN_ID: begin
				if (stat.scan_end) begin
					res_status_d = ST_NOTFOUND;
					state_d      = S_EMIT;
				end else if (stat.id_match) begin
					ctrl.save_match = 1'b1;
					res_status_d    = ST_OK;
					case (stat.cmd)
						CMD_REMOVE: begin
							ctrl.do_delete = 1'b1;
							state_d        = S_EMIT;
						end
						CMD_REPRIO: begin
							ctrl.do_delete = 1'b1;
							ctrl.idx_clr   = 1'b1;
							state_d        = S_SCAN_PRIO;
						end
						default: state_d = S_EMIT;
					endcase
				end else begin
					ctrl.idx_inc = 1'b1;
				end
			end
			// one transfer per entry
			S_LIST: begin
				if (stat.out_free) begin
					ctrl.load_out = 1'b1;
					ctrl.out_list = 1'b1;
					ctrl.idx_inc  = 1'b1;
					if (stat.list_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					ctrl.load_out = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/spl_datapath.sv =====
// Datapath of the sorted priority list: request latch, row of sorted slots,
// scan index, fill count and output register. Depends on spl_pkg.
module spl_datapath #(
	parameter int DEPTH = spl_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [spl_pkg::CMD_W-1:0]  in_command,
	input  logic [spl_pkg::ID_W-1:0]   in_patient_id,
	input  logic [spl_pkg::PRIO_W-1:0] in_priority_req,
	input  spl_pkg::spl_ctrl_t         ctrl,
	output spl_pkg::spl_stat_t         stat,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [spl_pkg::ST_W-1:0]   out_status,
	output logic [spl_pkg::ID_W-1:0]   out_entry_id,
	output logic [spl_pkg::PRIO_W-1:0] out_entry_priority,
	output logic [spl_pkg::POS_W-1:0]  out_position,
	output logic [spl_pkg::POS_W-1:0]  out_occupancy,
	output logic                      out_last
);
	import spl_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CMD_W-1:0]  cmd_q;
	logic [ID_W-1:0]   req_id_q;
	logic [PRIO_W-1:0] req_prio_q;
	logic [ID_W-1:0]   slot_id_q   [DEPTH];
	logic [PRIO_W-1:0] slot_prio_q [DEPTH];
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [PRIO_W-1:0] pend_prio_q;
	logic [CW-1:0]     pend_pos_q;
	logic [ID_W-1:0]   rd_id;
	logic [PRIO_W-1:0] rd_prio;
	logic              list_last;

	logic              out_valid_q;
	logic [ST_W-1:0]   out_status_q;
	logic [ID_W-1:0]   out_id_q;
	logic [PRIO_W-1:0] out_prio_q;
	logic [POS_W-1:0]  out_pos_q;
	logic [POS_W-1:0]  out_occ_q;
	logic              out_last_q;

	// request latch
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			req_id_q   <= in_patient_id;
			req_prio_q <= in_priority_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_ADD;
		end else if (ctrl.capture) begin
			cmd_q <= in_command;
		end
	end

	// slot at the scan index
	assign rd_id     = slot_id_q[idx_q[IW-1:0]];
	assign rd_prio   = slot_prio_q[idx_q[IW-1:0]];
	assign list_last = (idx_q + CW'(1)) == count_q;

	// row of slots: insert shifts toward the tail, delete toward the head
	for (genvar g = 0; g < DEPTH; g++) begin : g_slot
		localparam int PREV = (g == 0) ? 0 : g - 1;
		localparam int NEXT = (g == DEPTH - 1) ? g : g + 1;

		always_ff @(posedge clk) begin
			if (ctrl.do_insert) begin
				if (CW'(g) == idx_q) begin
					slot_id_q[g]   <= req_id_q;
					slot_prio_q[g] <= req_prio_q;
				end else if (CW'(g) > idx_q) begin
					slot_id_q[g]   <= slot_id_q[PREV];
					slot_prio_q[g] <= slot_prio_q[PREV];
				end
			end else if (ctrl.do_delete) begin
				if (CW'(g) >= idx_q) begin
					slot_id_q[g]   <= slot_id_q[NEXT];
					slot_prio_q[g] <= slot_prio_q[NEXT];
				end
			end
		end
	end

	// fill count and scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (ctrl.do_insert) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.do_delete) begin
				count_q <= count_q - CW'(1);
			end
			if (ctrl.idx_clr) begin
				idx_q <= '0;
			end else if (ctrl.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// reported entry for single results
	always_ff @(posedge clk) begin
		if (ctrl.do_insert) begin
			pend_prio_q <= req_prio_q;
			pend_pos_q  <= idx_q;
		end else if (ctrl.save_match) begin
			pend_prio_q <= rd_prio;
			pend_pos_q  <= idx_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			out_occ_q <= POS_W'(count_q);
			if (ctrl.out_list) begin
				out_status_q <= ST_OK;
				out_id_q     <= rd_id;
				out_prio_q   <= rd_prio;
				out_pos_q    <= POS_W'(idx_q);
				out_last_q   <= list_last;
			end else if (ctrl.out_status == ST_OK) begin
				out_status_q <= ST_OK;
				out_id_q     <= req_id_q;
				out_prio_q   <= pend_prio_q;
				out_pos_q    <= POS_W'(pend_pos_q);
				out_last_q   <= 1'b1;
			end else begin
				out_status_q <= ctrl.out_status;
				out_id_q     <= '0;
				out_prio_q   <= '0;
				out_pos_q    <= '0;
				out_last_q   <= 1'b1;
			end
		end
	end

	// status to controller
	always_comb begin
		stat.cmd       = cmd_q;
		stat.empty     = count_q == '0;
		stat.full      = count_q == CW'(DEPTH);
		stat.scan_end  = idx_q == count_q;
		stat.id_match  = rd_id == req_id_q;
		stat.prio_le   = rd_prio <= req_prio_q;
		stat.list_last = list_last;
		stat.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid          = out_valid_q;
	assign out_status         = out_status_q;
	assign out_entry_id       = out_id_q;
	assign out_entry_priority = out_prio_q;
	assign out_position       = out_pos_q;
	assign out_occupancy      = out_occ_q;
	assign out_last           = out_last_q;

endmodule

// ===== rtl/core/sorted_priority_list_top.sv =====
// Sorted priority list, one command at a time. A command is taken only when idle.
// Add: scans past each slot of lower/equal priority, then inserts and reports the result.
// Remove/find: scan for the matching id; reprioritize adds the insertion scan.
// List: one result per cycle while the output register can take it; scan of one slot per cycle sets rate.
// Reset clears the fill count and control state at once; slot contents need no clearing.
// Depends on spl_pkg, spl_cmd_if, spl_res_if, spl_ctrl and spl_datapath.
module sorted_priority_list_top #(
	parameter int DEPTH = spl_pkg::DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	spl_cmd_if.sink   cmd_in,
	spl_res_if.source res_out
);
	import spl_pkg::*;

	spl_ctrl_t ctrl;
	spl_stat_t stat;

	spl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_in.valid),
		.in_ready (cmd_in.ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	spl_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_command         (cmd_in.command),
		.in_patient_id      (cmd_in.patient_id),
		.in_priority_req    (cmd_in.priority_req),
		.ctrl               (ctrl),
		.stat               (stat),
		.out_valid          (res_out.valid),
		.out_ready          (res_out.ready),
		.out_status         (res_out.status),
		.out_entry_id       (res_out.entry_id),
		.out_entry_priority (res_out.entry_priority),
		.out_position       (res_out.position),
		.out_occupancy      (res_out.occupancy),
		.out_last           (res_out.last)
	);

endmodule

// ===== rtl/core/spl_checker.sv =====
// Port-level checker for sorted_priority_list_top, attached by bind.
// Depends on spl_pkg and sorted_priority_list_top_macros.svh.
`include "sorted_priority_list_top_macros.svh"

module spl_checker #(
	parameter int DEPTH = spl_pkg::DEPTH_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [spl_pkg::ST_W-1:0]  status,
	input logic [spl_pkg::ID_W-1:0]  entry_id,
	input logic [spl_pkg::POS_W-1:0] position,
	input logic [spl_pkg::POS_W-1:0] occupancy,
	input logic                      last
);
	import spl_pkg::*;

	// a waiting result stays in place
	`SPL_ASSERT(a_out_hold, (out_valid && !out_ready |=> out_valid && $stable(entry_id)), "result changed while stalled")

	// one command in flight: no transfer right after a transfer
	`SPL_ASSERT(a_one_cmd, (in_valid && in_ready |=> !in_ready), "request taken while busy")

	// error results carry no entry and end the command
	`SPL_ASSERT(a_err_zero, (out_valid && status != ST_OK |-> entry_id == '0 && position == '0 && last), "error result not cleared")

	// full and empty reports agree with occupancy
	`SPL_ASSERT(a_full_occ, (out_valid && status == ST_FULL |-> occupancy == POS_W'(DEPTH)), "full reported below capacity")
	`SPL_ASSERT(a_empty_occ, (out_valid && status == ST_EMPTY |-> occupancy == '0), "empty reported with entries")

endmodule

bind sorted_priority_list_top spl_checker #(
	.DEPTH (DEPTH)
) u_spl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cmd_in.valid),
	.in_ready  (cmd_in.ready),
	.out_valid (res_out.valid),
	.out_ready (res_out.ready),
	.status    (res_out.status),
	.entry_id  (res_out.entry_id),
	.position  (res_out.position),
	.occupancy (res_out.occupancy),
	.last      (res_out.last)
);
